[hdl/ipc_pkg.sv]
package ipc_pkg;

	localparam int FIELD_W = 8;
	localparam int COUNT_W = 31;

	localparam logic [COUNT_W-1:0] COUNT_CAP = {COUNT_W{1'b1}};

	typedef logic signed [FIELD_W-1:0] field_t;
	typedef logic [COUNT_W-1:0] count_t;

endpackage

[hdl/ipc_req_if.sv]
interface ipc_req_if import ipc_pkg::*; ();
	logic   valid;
	logic   ready;
	field_t max_part;
	field_t total;

	modport source (output valid, output max_part, output total, input ready);
	modport sink (input valid, input max_part, input total, output ready);
endinterface

[hdl/ipc_rsp_if.sv]
interface ipc_rsp_if import ipc_pkg::*; ();
	logic   valid;
	logic   ready;
	count_t count;
	logic   range_error;

	modport source (output valid, output count, output range_error, input ready);
	modport sink (input valid, input count, input range_error, output ready);
endinterface

[hdl/ipc_row_mem.sv]
module ipc_row_mem import ipc_pkg::*; #(
	parameter int DEPTH = 65
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  count_t                   wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output count_t                   rdata_a,
	output count_t                   rdata_b
);

	count_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data registered; holds when no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

[hdl/ipc_sat_add.sv]
module ipc_sat_add import ipc_pkg::*; (
	input  count_t a,
	input  count_t b,
	output count_t sum
);

	logic [COUNT_W:0] full;

	assign full = {1'b0, a} + {1'b0, b};
	// carry out means past the cap
	assign sum = full[COUNT_W] ? COUNT_CAP : full[COUNT_W-1:0];

endmodule

[hdl/integer_partition_count.sv]
// integer_partition_count: partitions of n into parts no larger than k.
// Flow: clear the row, then one add pass per part size p=1..k over entries p..n, then
//   read entry n; special cases (k or n <= 0, n > MAX_N) skip the table entirely.
// Throughput: one transaction at a time; the saturating adder and the row memory
//   handle one table update per cycle, so the add passes set the rate.
// Reset: arst_n asynchronous, active low; clears the sequencer and output valid only.
module integer_partition_count import ipc_pkg::*; #(
	parameter int MAX_N = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	ipc_req_if.sink  req,
	ipc_rsp_if.source rsp
);

	localparam int DEPTH = MAX_N + 1;
	localparam int AW    = $clog2(DEPTH);

	typedef logic [AW-1:0] idx_t;

	// one-hot sequencer
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CLEAR = 6'b000010, // zero the row, entry 0 gets 1
		S_RUN   = 6'b000100, // one table update issued per cycle
		S_GAP   = 6'b001000, // drain the last write of a pass
		S_FETCH = 6'b010000, // read entry n
		S_DONE  = 6'b100000  // hand the result to the output register
	} state_t;

	state_t state_q;

	idx_t n_q;      // n
	idx_t k_q;      // min(k, n)
	idx_t p_q;      // current part size
	idx_t j_q;      // row index; also the clear pointer
	logic use_mem_q;  // result comes from the row (not a special case)
	logic one_q;      // special-case count: 0 or 1
	logic err_q;      // range error for this transaction

	// update stage: read data lands here in the cycle after issue
	logic v_s1;
	idx_t wj_s1;
	logic fwd_s1;     // part size 1: j-1 is being written as j is read
	count_t last_q;   // value written in the previous update

	// output register
	logic   out_valid_q;
	count_t count_q;
	logic   rerr_q;

	// memory and adder hookup
	logic   mem_we;
	idx_t   mem_waddr;
	count_t mem_wdata;
	logic   mem_re;
	idx_t   mem_raddr_a;
	idx_t   mem_raddr_b;
	count_t rdata_a;
	count_t rdata_b;
	count_t add_b;
	count_t sum;

	// input decode
	logic [FIELD_W-2:0] k_mag;
	logic [FIELD_W-2:0] n_mag;
	logic               is_neg;
	logic               is_over;
	logic               out_free;

	assign k_mag   = req.max_part[FIELD_W-2:0];
	assign n_mag   = req.total[FIELD_W-2:0];
	assign is_neg  = req.max_part[FIELD_W-1] | req.total[FIELD_W-1];
	assign is_over = !is_neg && (n_mag > (FIELD_W-1)'(MAX_N));
	assign out_free = !out_valid_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid       = out_valid_q;
	assign rsp.count       = count_q;
	assign rsp.range_error = rerr_q;

	// write port: clear sweep or the update stage, never both
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wj_s1;
		mem_wdata = sum;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = j_q;
			mem_wdata = (j_q == '0) ? count_t'(1) : '0;
		end else if (v_s1) begin
			mem_we = 1'b1;
		end
	end

	assign mem_re      = (state_q == S_RUN) || (state_q == S_FETCH);
	assign mem_raddr_a = (state_q == S_FETCH) ? n_q : j_q;
	assign mem_raddr_b = j_q - p_q;

	assign add_b = fwd_s1 ? last_q : rdata_b;

	ipc_row_mem #(
		.DEPTH(DEPTH)
	) u_row (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	ipc_sat_add u_add (
		.a   (rdata_a),
		.b   (add_b),
		.sum (sum)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			k_q         <= '0;
			p_q         <= '0;
			j_q         <= '0;
			use_mem_q   <= 1'b0;
			one_q       <= 1'b0;
			err_q       <= 1'b0;
			v_s1        <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1   <= (state_q == S_RUN);
			fwd_s1 <= (state_q == S_RUN) && (p_q == idx_t'(1)) && (j_q != idx_t'(1));
			if (rsp.valid && rsp.ready && !((state_q == S_DONE) && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						err_q <= is_over;
						if (!is_neg && !is_over && (n_mag != '0) && (k_mag != '0)) begin
							// k above n behaves as k equal to n
							n_q       <= n_mag[AW-1:0];
							k_q       <= (k_mag > n_mag) ? n_mag[AW-1:0] : k_mag[AW-1:0];
							j_q       <= '0;
							use_mem_q <= 1'b1;
							one_q     <= 1'b0;
							state_q   <= S_CLEAR;
						end else begin
							use_mem_q <= 1'b0;
							one_q     <= !is_neg && !is_over && (n_mag == '0);
							state_q   <= S_DONE;
						end
					end
				end
				S_CLEAR: begin
					if (j_q == n_q) begin
						p_q     <= idx_t'(1);
						j_q     <= idx_t'(1);
						state_q <= S_RUN;
					end else begin
						j_q <= j_q + idx_t'(1);
					end
				end
				S_RUN: begin
					if (j_q == n_q) begin
						state_q <= S_GAP;
					end else begin
						j_q <= j_q + idx_t'(1);
					end
				end
				S_GAP: begin
					if (p_q == k_q) begin
						state_q <= S_FETCH;
					end else begin
						p_q     <= p_q + idx_t'(1);
						j_q     <= p_q + idx_t'(1);
						state_q <= S_RUN;
					end
				end
				S_FETCH: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (v_s1) begin
			last_q <= sum;
		end
		if (state_q == S_RUN) begin
			wj_s1 <= j_q;
		end
		if ((state_q == S_DONE) && out_free) begin
			count_q <= use_mem_q ? rdata_a : count_t'(one_q);
			rerr_q  <= err_q;
		end
	end

	// a range error always carries a zero count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.range_error |-> rsp.count == '0)
		else $error("range error with nonzero count");

	// update indices stay inside the active row segment
	a_run_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> (p_q <= j_q) && (j_q <= n_q) && (p_q <= k_q))
		else $error("update index out of range");

	// the clear sweep and the update stage never share the write port
	a_wr_port: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> state_q != S_CLEAR)
		else $error("write port conflict");

	// a taken transaction holds off the next one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second transaction accepted while busy");

	// a finished result reaches the output register
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_free |=> rsp.valid)
		else $error("result lost");

endmodule
